>>> src/aes_ecb_encrypt_pkcs7_macros.svh
// Assertion macros for the AES ECB PKCS#7 encryptor.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef AES_ECB_ENCRYPT_PKCS7_MACROS_SVH
`define AES_ECB_ENCRYPT_PKCS7_MACROS_SVH

// Check a property at every clock edge outside reset.
`define AESP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("aesp assertion failed");

// Check that a condition in one cycle implies another in the next.
`define AESP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aesp assertion failed");

`endif

>>> src/aesp_pkg.sv
// Package for the AES ECB PKCS#7 encryptor: payload types, states, S-box.
// No dependencies; used by aesp_col and aes_ecb_encrypt_pkcs7.
`default_nettype none
package aesp_pkg;

  localparam int unsigned CfgAddrW = 6;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_KLEN = 3'd4;

  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        is_final;
    logic [3:0]  final_count;
  } req_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic add_only;
    logic no_mix;
  } col_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = SBOX[w[8*b +: 8]];
    end
    sub_word = r;
  endfunction

endpackage
`default_nettype wire

>>> src/aesp_col.sv
// One AES state column per cycle: SubBytes on the diagonal, MixColumns, AddRoundKey;
// no_mix skips MixColumns and add_only applies AddRoundKey alone. Depends on aesp_pkg.
`default_nettype none
module aesp_col (
  input  wire logic [31:0]       diag_i,
  input  wire logic [31:0]       rk_i,
  input  wire aesp_pkg::col_ctl_t ctl_i,
  output logic [31:0]            col_o
);
  logic [31:0] sb;
  logic [7:0]  a0, a1, a2, a3, all;
  logic [31:0] mx;

  always_comb begin
    sb  = aesp_pkg::sub_word(diag_i);
    a0  = sb[31:24];
    a1  = sb[23:16];
    a2  = sb[15:8];
    a3  = sb[7:0];
    all = a0 ^ a1 ^ a2 ^ a3;
    mx  = {a0 ^ all ^ aesp_pkg::xtime(a0 ^ a1),
           a1 ^ all ^ aesp_pkg::xtime(a1 ^ a2),
           a2 ^ all ^ aesp_pkg::xtime(a2 ^ a3),
           a3 ^ all ^ aesp_pkg::xtime(a3 ^ a0)};
    if (ctl_i.add_only) begin
      col_o = diag_i ^ rk_i;
    end else if (ctl_i.no_mix) begin
      col_o = sb ^ rk_i;
    end else begin
      col_o = mx ^ rk_i;
    end
  end
endmodule
`default_nettype wire

>>> src/aes_ecb_encrypt_pkcs7.sv
// AES-128/192/256 ECB encryptor with PKCS#7 padding of the final block.
// Depends on aesp_pkg, aesp_col and aes_ecb_encrypt_pkcs7_macros.svh.
//
// Usage:
//   Write the key words and key length over the APB port (8-byte register
//   stride, pready always high) while the block is idle.
//   Issue a request by raising start_i with data_i while busy_o is low; the
//   request is taken at that edge and busy_o rises.
//   The state is processed one 32-bit column per cycle, and the key schedule
//   produces one round-key word per cycle in step with it.
//   result_valid_o then pulses for one cycle with result_o, in the same cycle
//   busy_o falls; a new request may be issued in that cycle.
//   One request at a time.
//   The receiver cannot stall; a result is shown exactly once.
//   Reset clears the key registers to zero and returns the block to idle.
//   A final request pads bytes from final_count on with 16 - final_count.
`default_nettype none
`include "aes_ecb_encrypt_pkcs7_macros.svh"
module aes_ecb_encrypt_pkcs7 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire aesp_pkg::req_t                data_i,
  output logic                               busy_o,
  output logic                               result_valid_o,
  output aesp_pkg::rsp_t                     result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [aesp_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [63:0]                   pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);
  logic [63:0] key_q [4];
  logic [1:0]  klen_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  aesp_pkg::state_e state_q, state_d;
  logic [5:0]  j_q, j_d;
  logic        done_q, done_d;
  logic        last_q;
  logic [31:0] st_q [4];
  logic [31:0] st_d [4];
  logic [31:0] nw_q [3];
  logic [31:0] nw_d [3];
  logic [31:0] kw_q [8];
  logic [31:0] kw_d [8];
  logic [2:0]  km_q, km_d;
  logic [7:0]  rcon_q, rcon_d;

  logic        accept;
  logic        last_cyc;
  logic [3:0]  nr;
  logic [2:0]  nk_m1;
  logic [5:0]  j_last;
  logic [3:0]  rnd;
  logic [127:0] blk;
  logic [127:0] padded;
  logic [31:0] diag;
  logic [31:0] newcol;
  logic [31:0] kt, kt_sel, newk;
  aesp_pkg::col_ctl_t ctl;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];

  always_comb begin
    case (reg_idx)
      aesp_pkg::REG_KEY0: prdata = key_q[0];
      aesp_pkg::REG_KEY1: prdata = key_q[1];
      aesp_pkg::REG_KEY2: prdata = key_q[2];
      aesp_pkg::REG_KEY3: prdata = key_q[3];
      aesp_pkg::REG_KLEN: prdata = {62'd0, klen_q};
      default:            prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        key_q[k] <= 64'd0;
      end
      klen_q <= aesp_pkg::KLEN_128;
    end else if (wr_en) begin
      case (reg_idx)
        aesp_pkg::REG_KEY0: key_q[0] <= pwdata;
        aesp_pkg::REG_KEY1: key_q[1] <= pwdata;
        aesp_pkg::REG_KEY2: key_q[2] <= pwdata;
        aesp_pkg::REG_KEY3: key_q[3] <= pwdata;
        aesp_pkg::REG_KLEN: klen_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (klen_q)
      aesp_pkg::KLEN_128: begin
        nr = 4'd10; nk_m1 = 3'd3; j_last = 6'd43;
      end
      aesp_pkg::KLEN_192: begin
        nr = 4'd12; nk_m1 = 3'd5; j_last = 6'd51;
      end
      default: begin
        nr = 4'd14; nk_m1 = 3'd7; j_last = 6'd59;
      end
    endcase
  end

  assign accept   = start_i && !busy_o;
  assign last_cyc = (state_q == aesp_pkg::ST_RUN) && (j_q == j_last);
  assign rnd      = j_q[5:2];

  always_comb begin
    state_d = state_q;
    case (state_q)
      aesp_pkg::ST_IDLE: if (accept) state_d = aesp_pkg::ST_RUN;
      aesp_pkg::ST_RUN:  if (last_cyc) state_d = aesp_pkg::ST_IDLE;
      default:           state_d = aesp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q == aesp_pkg::ST_RUN);
    done_d = last_cyc;
    j_d    = accept ? 6'd0 : (busy_o ? j_q + 6'd1 : j_q);
  end

  always_comb begin
    blk = {data_i.data_high, data_i.data_low};
    for (int i = 0; i < 16; i++) begin
      if (data_i.is_final && (5'(i) >= {1'b0, data_i.final_count})) begin
        padded[127-8*i -: 8] = 8'd16 - {4'd0, data_i.final_count};
      end else begin
        padded[127-8*i -: 8] = blk[127-8*i -: 8];
      end
    end
  end

  always_comb begin
    ctl.add_only = (rnd == 4'd0);
    ctl.no_mix   = (rnd == nr);
    if (ctl.add_only) begin
      diag = st_q[0];
    end else begin
      diag = {st_q[0][31:24], st_q[1][23:16], st_q[2][15:8], st_q[3][7:0]};
    end
  end

  aesp_col u_col (
    .diag_i (diag),
    .rk_i   (kw_q[0]),
    .ctl_i  (ctl),
    .col_o  (newcol)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      st_d[k] = st_q[k];
    end
    for (int k = 0; k < 3; k++) begin
      nw_d[k] = nw_q[k];
    end
    if (accept) begin
      for (int k = 0; k < 4; k++) begin
        st_d[k] = padded[127-32*k -: 32];
      end
    end else if (busy_o) begin
      if (j_q[1:0] == 2'd3) begin
        st_d[0] = nw_q[0];
        st_d[1] = nw_q[1];
        st_d[2] = nw_q[2];
        st_d[3] = newcol;
      end else begin
        st_d[0] = st_q[1];
        st_d[1] = st_q[2];
        st_d[2] = st_q[3];
        st_d[3] = st_q[0];
        nw_d[0] = nw_q[1];
        nw_d[1] = nw_q[2];
        nw_d[2] = newcol;
      end
    end
  end

  always_comb begin
    kt_sel = kw_q[nk_m1];
    if (km_q == 3'd0) begin
      kt = aesp_pkg::sub_word({kt_sel[23:0], kt_sel[31:24]}) ^ {rcon_q, 24'd0};
    end else if ((nk_m1 == 3'd7) && (km_q == 3'd4)) begin
      kt = aesp_pkg::sub_word(kt_sel);
    end else begin
      kt = kt_sel;
    end
    newk = kw_q[0] ^ kt;
    for (int k = 0; k < 8; k++) begin
      kw_d[k] = kw_q[k];
    end
    km_d   = km_q;
    rcon_d = rcon_q;
    if (accept) begin
      for (int k = 0; k < 8; k++) begin
        kw_d[k] = key_q[k/2][63-32*(k%2) -: 32];
      end
      km_d   = 3'd0;
      rcon_d = 8'h01;
    end else if (busy_o) begin
      for (int k = 0; k < 7; k++) begin
        kw_d[k] = kw_q[k+1];
      end
      kw_d[nk_m1] = newk;
      km_d   = (km_q == nk_m1) ? 3'd0 : km_q + 3'd1;
      rcon_d = (km_q == 3'd0) ? aesp_pkg::xtime(rcon_q) : rcon_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aesp_pkg::ST_IDLE;
      done_q  <= 1'b0;
      j_q     <= 6'd0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      st_q[k] <= st_d[k];
    end
    for (int k = 0; k < 3; k++) begin
      nw_q[k] <= nw_d[k];
    end
    for (int k = 0; k < 8; k++) begin
      kw_q[k] <= kw_d[k];
    end
    km_q   <= km_d;
    rcon_q <= rcon_d;
    if (accept) begin
      last_q <= data_i.is_final;
    end
  end

  assign result_valid_o       = done_q;
  assign result_o.cipher_high = {st_q[0], st_q[1]};
  assign result_o.cipher_low  = {st_q[2], st_q[3]};
  assign result_o.last        = last_q;

  `AESP_ASSERT_NEXT(a_accept_busy, accept, busy_o)
  `AESP_ASSERT_NEXT(a_done_after_last, last_cyc, done_q && !busy_o)
  `AESP_ASSERT(a_count_bound, !busy_o || (j_q <= j_last))

endmodule
`default_nettype wire

>>> tb/aes_ecb_checker.sv
// Checker for the AES ECB PKCS#7 encryptor: tracks key register writes, predicts
// the ciphertext of each accepted request and compares every result against it.
// Depends on aesp_pkg for the payload types, register codes and the S-box table.
`default_nettype none
module aes_ecb_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_start_i,
  input  wire aesp_pkg::req_t                req_i,
  input  wire logic                          busy_i,
  input  wire logic                          rsp_valid_i,
  input  wire aesp_pkg::rsp_t                rsp_i,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [aesp_pkg::CfgAddrW-1:0] paddr_i,
  input  wire logic [63:0]                   pwdata_i,
  output int                                 pending_o,
  output int                                 fails_o
);
  logic [63:0]    key_reg [4];
  logic [1:0]     klen_reg;
  aesp_pkg::rsp_t cipher_q [$];

  initial begin
    pending_o = 0;
    fails_o = 0;
    for (int k = 0; k < 4; k++) key_reg[k] = '0;
    klen_reg = aesp_pkg::KLEN_128;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] v);
    return {aesp_pkg::SBOX[v[31:24]], aesp_pkg::SBOX[v[23:16]],
            aesp_pkg::SBOX[v[15:8]], aesp_pkg::SBOX[v[7:0]]};
  endfunction

  function automatic aesp_pkg::rsp_t encrypt_block(input aesp_pkg::req_t r);
    logic [31:0] rk [60];
    logic [7:0]  st [16];
    logic [7:0]  tmp [16];
    logic [31:0] t;
    logic [7:0]  rcon;
    logic [7:0]  a0, a1, a2, a3, all;
    logic [127:0] blk;
    int nk, nr;
    aesp_pkg::rsp_t o;
    nk = (klen_reg == aesp_pkg::KLEN_128) ? 4 : (klen_reg == aesp_pkg::KLEN_192) ? 6 : 8;
    nr = nk + 6;
    rcon = 8'h01;
    for (int i = 0; i < nk; i++)
      rk[i] = (i % 2 == 0) ? key_reg[i/2][63:32] : key_reg[i/2][31:0];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = rk[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_double(rcon);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      rk[i] = rk[i-nk] ^ t;
    end
    blk = {r.data_high, r.data_low};
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
    if (r.is_final)
      for (int i = 0; i < 16; i++)
        if (i >= r.final_count) st[i] = 8'd16 - {4'd0, r.final_count};
    for (int rd = 0; rd <= nr; rd++) begin
      if (rd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) tmp[4*c+w] = aesp_pkg::SBOX[st[4*((c+w)%4)+w]];
        st = tmp;
        if (rd != nr)
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
            st[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
            st[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
            st[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
          end
      end
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) st[4*c+w] ^= rk[4*rd+c][31-8*w -: 8];
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = st[i];
    o.cipher_high = blk[127:64];
    o.cipher_low = blk[63:0];
    o.last = r.is_final;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    fails_o++;
  endtask

  always @(posedge clk_i) begin
    aesp_pkg::rsp_t want;
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i) begin
        case (paddr_i[5:3])
          aesp_pkg::REG_KEY0: key_reg[0] = pwdata_i;
          aesp_pkg::REG_KEY1: key_reg[1] = pwdata_i;
          aesp_pkg::REG_KEY2: key_reg[2] = pwdata_i;
          aesp_pkg::REG_KEY3: key_reg[3] = pwdata_i;
          aesp_pkg::REG_KLEN: klen_reg = pwdata_i[1:0];
          default: ;
        endcase
      end
      if (rsp_valid_i) begin
        if (cipher_q.size() == 0) begin
          report_mismatch("unexpected result", rsp_i.cipher_high, '0);
        end else begin
          want = cipher_q.pop_front();
          if (rsp_i.cipher_high !== want.cipher_high)
            report_mismatch("cipher_high", rsp_i.cipher_high, want.cipher_high);
          if (rsp_i.cipher_low !== want.cipher_low)
            report_mismatch("cipher_low", rsp_i.cipher_low, want.cipher_low);
          if (rsp_i.last !== want.last)
            report_mismatch("last", {63'd0, rsp_i.last}, {63'd0, want.last});
        end
      end
      if (req_start_i && !busy_i) cipher_q.push_back(encrypt_block(req_i));
      pending_o = cipher_q.size();
    end
  end
endmodule
`default_nettype wire

>>> tb/testbench.sv
// Top of the AES ECB PKCS#7 encryptor regression: clock, reset, key setup and
// request stimulus. Depends on aesp_pkg, the encryptor and aes_ecb_checker.
`default_nettype none
module testbench;
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  aesp_pkg::req_t                data_i = '0;
  logic                          busy_o;
  logic                          result_valid_o;
  aesp_pkg::rsp_t                result_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [aesp_pkg::CfgAddrW-1:0] paddr = '0;
  logic [63:0]                   pwdata = '0;
  logic [63:0]                   prdata;
  logic                          pready;
  int                            pending;
  int                            fails;
  bit                            gaps_on;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  aes_ecb_encrypt_pkcs7 dut (
    .clk_i, .rst_ni, .start_i, .data_i, .busy_o, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  aes_ecb_checker u_checker (
    .clk_i, .rst_ni, .req_start_i(start_i), .req_i(data_i), .busy_i(busy_o),
    .rsp_valid_i(result_valid_o), .rsp_i(result_o), .psel_i(psel),
    .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata),
    .pending_o(pending), .fails_o(fails)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic load_key(input logic [63:0] k0, k1, k2, k3, input logic [63:0] klen);
    drain();
    reg_write(aesp_pkg::REG_KEY0, k0);
    reg_write(aesp_pkg::REG_KEY1, k1);
    reg_write(aesp_pkg::REG_KEY2, k2);
    reg_write(aesp_pkg::REG_KEY3, k3);
    reg_write(aesp_pkg::REG_KLEN, klen);
    if ($urandom_range(0, 1)) reg_write(3'($urandom_range(5, 7)), rand64());
    @(negedge clk_i);
  endtask

  task automatic send_request(input aesp_pkg::req_t r);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (busy_o) begin
      start_i <= 1'b0;
      @(negedge clk_i);
      while (busy_o) @(negedge clk_i);
    end
    start_i <= 1'b1;
    data_i <= r;
    @(negedge clk_i);
  endtask

  task automatic random_requests(input int n);
    aesp_pkg::req_t r;
    for (int i = 0; i < n; i++) begin
      r.data_high = rand64();
      r.data_low = rand64();
      r.is_final = ($urandom_range(0, 3) == 0);
      r.final_count = 4'($urandom_range(0, 15));
      send_request(r);
      if (i == n / 2 && $urandom_range(0, 1)) drain();
    end
  endtask

  initial begin
    aesp_pkg::req_t r;
    gaps_on = 1'b1;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '0, '0,
             64'(aesp_pkg::KLEN_128));
    send_request('{64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b0, 4'd0});
    send_request('{'0, '0, 1'b0, 4'hf});
    send_request('{'1, '1, 1'b0, 4'd0});
    for (int c = 0; c < 16; c++) begin
      r.data_high = (c % 2) ? '1 : rand64();
      r.data_low = (c % 2) ? '0 : rand64();
      r.is_final = 1'b1;
      r.final_count = 4'(c);
      send_request(r);
    end
    drain();

    load_key('1, '1, '1, '1, 64'(aesp_pkg::KLEN_192));
    send_request('{'1, '1, 1'b1, 4'hf});
    send_request('{'0, '0, 1'b1, 4'd0});
    load_key('0, '0, '0, '0, 64'd2);
    send_request('{'0, '0, 1'b0, 4'd0});
    load_key(rand64(), rand64(), rand64(), rand64(), 64'hffff_ffff_ffff_ffff);
    send_request('{'1, '0, 1'b0, 4'd7});

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) gaps_on = 1'b0;
      load_key(rand64(), rand64(), rand64(), rand64(),
               {$urandom, $urandom_range(0, 3)});
      random_requests(130);
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (fails == 0) begin
      $display("aes_ecb_encrypt_pkcs7 regression: pass");
    end else begin
      $display("aes_ecb_encrypt_pkcs7 regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("aes_ecb_encrypt_pkcs7 regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
